[hdl/lru_pkg.sv]
// shared constants and types for the lru cache with expiry
`timescale 1ns / 1ps
package lru_pkg;
    localparam int ENTRIES    = 16;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int TIME_BITS  = 32;
    localparam int CAP_BITS   = 5;
    localparam int TTL_BITS   = 16;
    localparam int CFG_BITS   = 64;

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_DEL    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_TTL      = 1'b1;

    typedef struct packed {
        logic load;
        logic drop_hit;
        logic drop_victim;
        logic refresh;
        logic insert;
        logic respond;
    } lru_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       key_zero;
        logic       hit;
        logic       live_set;
        logic       live_get;
        logic       full;
        logic       any_valid;
        logic       has_free;
    } lru_status_t;
endpackage

[hdl/lru_datapath.sv]
// entry storage, parallel match, recency ranks and result registers
`timescale 1ns / 1ps
module lru_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  lru_pkg::lru_cmd_t               cmd,
    output lru_pkg::lru_status_t            status,
    input  logic [1:0]                      operation,
    input  logic [lru_pkg::KEY_BITS-1:0]    key,
    input  logic [lru_pkg::VALUE_BITS-1:0]  value,
    input  logic [lru_pkg::TIME_BITS-1:0]   now,
    input  logic [lru_pkg::CAP_BITS-1:0]    capacity,
    input  logic [lru_pkg::TTL_BITS-1:0]    time_to_live,
    output logic                            ok,
    output logic [lru_pkg::VALUE_BITS-1:0]  read_value
);
    import lru_pkg::*;

    logic [ENTRIES-1:0]     valid_reg;
    logic [KEY_BITS-1:0]    ekey_reg   [ENTRIES];
    logic [VALUE_BITS-1:0]  edata_reg  [ENTRIES];
    logic [TIME_BITS-1:0]   eexp_reg   [ENTRIES];
    logic [IDX_BITS-1:0]    rank_reg   [ENTRIES];
    logic [CNT_BITS-1:0]    count_reg;
    logic [1:0]             op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [VALUE_BITS-1:0]  val_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [TIME_BITS-1:0]   exp_reg;
    logic [TIME_BITS:0]     exp_sum;

    logic [ENTRIES-1:0]     match;
    logic                   hit;
    logic [IDX_BITS-1:0]    hit_idx;
    logic [IDX_BITS-1:0]    victim_idx;
    logic [IDX_BITS-1:0]    free_idx;
    logic                   has_free;
    logic [CNT_BITS-1:0]    cap_eff;
    logic [IDX_BITS-1:0]    sel_idx;

    assign exp_sum = {1'b0, now} + {{(TIME_BITS + 1 - TTL_BITS){1'b0}}, time_to_live};

    always_comb
    begin
        hit = 1'b0;
        hit_idx = '0;
        victim_idx = '0;
        free_idx = '0;
        has_free = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (ekey_reg[i] == key_reg);
            if (match[i])
            begin
                hit = 1'b1;
                hit_idx = IDX_BITS'(i);
            end
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = IDX_BITS'(i);
            end
            // largest rank is the least recent, ranks are unique among valid
            if (valid_reg[i] && rank_reg[i] == IDX_BITS'(count_reg - 1'b1))
                victim_idx = IDX_BITS'(i);
        end
        if (capacity == '0)
            cap_eff = CNT_BITS'(1);
        else if (32'(capacity) > ENTRIES)
            cap_eff = CNT_BITS'(ENTRIES);
        else
            cap_eff = CNT_BITS'(capacity);
    end

    assign status.op        = op_reg;
    assign status.key_zero  = (key_reg == '0);
    assign status.hit       = hit;
    assign status.live_set  = now_reg <= eexp_reg[hit_idx];
    assign status.live_get  = now_reg < eexp_reg[hit_idx];
    assign status.full      = count_reg >= cap_eff;
    assign status.any_valid = |valid_reg;
    assign status.has_free  = has_free;

    assign sel_idx = cmd.drop_victim ? victim_idx : hit_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            ok <= 1'b0;
            read_value <= '0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg  <= operation;
                key_reg <= key;
                val_reg <= value;
                now_reg <= now;
                exp_reg <= exp_sum[TIME_BITS] ? '1 : exp_sum[TIME_BITS-1:0];
            end
            if (cmd.drop_hit || cmd.drop_victim)
            begin
                valid_reg[sel_idx] <= 1'b0;
                for (int j = 0; j < ENTRIES; j++)
                    if (valid_reg[j] && rank_reg[j] > rank_reg[sel_idx])
                        rank_reg[j] <= rank_reg[j] - 1'b1;
                if (count_reg != '0)
                    count_reg <= count_reg - 1'b1;
            end
            if (cmd.refresh)
            begin
                for (int j = 0; j < ENTRIES; j++)
                    if (valid_reg[j] && rank_reg[j] < rank_reg[hit_idx])
                        rank_reg[j] <= rank_reg[j] + 1'b1;
                rank_reg[hit_idx] <= '0;
                if (op_reg == OP_SET)
                begin
                    edata_reg[hit_idx] <= val_reg;
                    eexp_reg[hit_idx]  <= exp_reg;
                end
            end
            if (cmd.insert && has_free)
            begin
                for (int j = 0; j < ENTRIES; j++)
                    if (valid_reg[j])
                        rank_reg[j] <= rank_reg[j] + 1'b1;
                valid_reg[free_idx] <= 1'b1;
                ekey_reg[free_idx]  <= key_reg;
                edata_reg[free_idx] <= val_reg;
                eexp_reg[free_idx]  <= exp_reg;
                rank_reg[free_idx]  <= '0;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.respond)
            begin
                unique case (op_reg)
                    OP_SET:
                    begin
                        ok <= !status.key_zero;
                        read_value <= '0;
                    end
                    OP_GET:
                    begin
                        ok <= hit && status.live_get;
                        read_value <= (hit && status.live_get) ? edata_reg[hit_idx] : '0;
                    end
                    OP_DEL:
                    begin
                        ok <= hit;
                        read_value <= '0;
                    end
                    default:
                    begin
                        ok <= 1'b0;
                        read_value <= '0;
                    end
                endcase
            end
        end
    end
endmodule

[hdl/lru_control.sv]
// request sequencer for the lru cache
`timescale 1ns / 1ps
module lru_control
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output lru_pkg::lru_cmd_t    cmd,
    input  lru_pkg::lru_status_t status
);
    import lru_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DROP, S_EVICT, S_INSERT, S_DONE} state_t;
    state_t state_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = (state_reg == S_IDLE) && start;
        unique case (state_reg)
            S_IDLE: ;
            S_DROP:
            begin
                cmd.respond = 1'b1;
                if (status.op == OP_SET && !status.key_zero)
                begin
                    if (status.hit && status.live_set)
                        cmd.refresh = 1'b1;
                    else if (status.hit)
                        cmd.drop_hit = 1'b1;
                end
                else if (status.op == OP_GET && status.hit)
                begin
                    if (status.live_get)
                        cmd.refresh = 1'b1;
                    else
                        cmd.drop_hit = 1'b1;
                end
                else if (status.op == OP_DEL && status.hit)
                    cmd.drop_hit = 1'b1;
            end
            S_EVICT:  cmd.drop_victim = status.full && status.any_valid;
            S_INSERT: cmd.insert = 1'b1;
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy <= 1'b0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        state_reg <= S_DROP;
                        busy <= 1'b1;
                    end
                S_DROP:
                    if (status.op == OP_SET && !status.key_zero
                        && !(status.hit && status.live_set))
                        state_reg <= S_EVICT;
                    else
                        state_reg <= S_DONE;
                S_EVICT:  state_reg <= S_INSERT;
                S_INSERT: state_reg <= S_DONE;
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                    busy <= 1'b0;
                    done <= 1'b1;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/lru_cache_with_ttl.sv]
// top level of the lru key-value cache with expiry
// a request steps from idle to drop, then through evict and insert for an inserting set, then to done
// a new request is taken only back in idle, after the last one has finished
// done strobes one cycle with ok and read_value; the receiver cannot stall
// reset clears all valid bits, ranks and the live count at once, no clearing pass
`timescale 1ns / 1ps
module lru_cache_with_ttl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      operation,
    input  logic [lru_pkg::KEY_BITS-1:0]    key,
    input  logic [lru_pkg::VALUE_BITS-1:0]  value,
    input  logic [lru_pkg::TIME_BITS-1:0]   now,
    output logic                            done,
    output logic                            ok,
    output logic [lru_pkg::VALUE_BITS-1:0]  read_value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [lru_pkg::CFG_BITS-1:0]    cfg_data
);
    import lru_pkg::*;

    logic [CAP_BITS-1:0] capacity_reg;
    logic [TTL_BITS-1:0] ttl_reg;
    lru_cmd_t            cmd;
    lru_status_t         status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_BITS'(16);
            ttl_reg <= TTL_BITS'(60);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CAPACITY: capacity_reg <= cfg_data[CAP_BITS-1:0];
                CFG_TTL:      ttl_reg <= cfg_data[TTL_BITS-1:0];
                default: ;
            endcase
        end
    end

    lru_control u_control
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cmd(cmd), .status(status)
    );

    lru_datapath u_datapath
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .operation(operation), .key(key), .value(value), .now(now),
        .capacity(capacity_reg), .time_to_live(ttl_reg),
        .ok(ok), .read_value(read_value)
    );
endmodule

[sim/lru_cache_with_ttl_test.sv]
// testbench for the lru key-value cache with expiry: directed table plus random traffic
`timescale 1ns / 1ps
module lru_cache_with_ttl_test;
    import lru_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            operation;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [TIME_BITS-1:0]  now;
    logic                  done;
    logic                  ok;
    logic [VALUE_BITS-1:0] read_value;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CFG_BITS-1:0]   cfg_data;

    typedef struct packed {
        logic                  ok;
        logic [VALUE_BITS-1:0] read_value;
    } reply_t;

    typedef struct {
        logic [1:0]            op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [TIME_BITS-1:0]  now;
        logic                  known;
        reply_t                reply;
    } request_t;

    // predictor state
    logic                  slot_valid [ENTRIES];
    logic [KEY_BITS-1:0]   slot_key [ENTRIES];
    logic [VALUE_BITS-1:0] slot_data [ENTRIES];
    logic [TIME_BITS-1:0]  slot_expiry [ENTRIES];
    int unsigned           slot_rank [ENTRIES];
    int unsigned           live;
    logic [CAP_BITS-1:0]   cur_capacity;
    logic [TTL_BITS-1:0]   cur_ttl;

    reply_t      pending_replies [$];
    request_t    directed [$];
    int          errors;
    int          replies_seen;
    int          idle_cycles;
    logic [KEY_BITS-1:0] key_pool [8];

    lru_cache_with_ttl u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string msg);
        $display("error: %s", msg);
        errors++;
    endtask

    function automatic int find_slot(input logic [KEY_BITS-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void remove_slot(input int i);
        int unsigned r;
        r = slot_rank[i];
        slot_valid[i] = 1'b0;
        for (int j = 0; j < ENTRIES; j++)
            if (slot_valid[j] && slot_rank[j] > r)
                slot_rank[j]--;
        if (live > 0)
            live--;
    endfunction

    function automatic void promote_slot(input int i);
        int unsigned r;
        r = slot_rank[i];
        for (int j = 0; j < ENTRIES; j++)
            if (slot_valid[j] && j != i && slot_rank[j] < r)
                slot_rank[j]++;
        slot_rank[i] = 0;
    endfunction

    function automatic void insert_slot(input logic [KEY_BITS-1:0] k,
                                        input logic [VALUE_BITS-1:0] v,
                                        input logic [TIME_BITS-1:0] e);
        int unsigned lim;
        int victim;
        int free_slot;
        lim = cur_capacity;
        victim = -1;
        free_slot = -1;
        if (lim == 0)
            lim = 1;
        if (lim > ENTRIES)
            lim = ENTRIES;
        if (live >= lim)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                    victim = i;
            if (victim >= 0)
                remove_slot(victim);
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (!slot_valid[i])
                free_slot = i;
        if (free_slot < 0)
            return;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i])
                slot_rank[i]++;
        slot_valid[free_slot] = 1'b1;
        slot_key[free_slot] = k;
        slot_data[free_slot] = v;
        slot_expiry[free_slot] = e;
        slot_rank[free_slot] = 0;
        live++;
    endfunction

    function automatic reply_t cache_access(input request_t rq);
        reply_t rp;
        logic [TIME_BITS:0] sum;
        logic [TIME_BITS-1:0] exp_time;
        int i;
        rp = '0;
        sum = {1'b0, rq.now} + cur_ttl;
        exp_time = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
        i = find_slot(rq.key);
        case (rq.op)
            OP_SET:
                if (rq.key != 0)
                begin
                    if (i >= 0 && rq.now <= slot_expiry[i])
                    begin
                        slot_data[i] = rq.value;
                        slot_expiry[i] = exp_time;
                        promote_slot(i);
                    end
                    else
                    begin
                        if (i >= 0)
                            remove_slot(i);
                        insert_slot(rq.key, rq.value, exp_time);
                    end
                    rp.ok = 1'b1;
                end
            OP_GET:
                if (i >= 0)
                begin
                    if (rq.now < slot_expiry[i])
                    begin
                        promote_slot(i);
                        rp.ok = 1'b1;
                        rp.read_value = slot_data[i];
                    end
                    else
                        remove_slot(i);
                end
            OP_DEL:
                if (i >= 0)
                begin
                    remove_slot(i);
                    rp.ok = 1'b1;
                end
            default:;
        endcase
        return rp;
    endfunction

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            replies_seen++;
            if (pending_replies.size() == 0)
                report("result with nothing expected");
            else
            begin
                reply_t exp_reply;
                exp_reply = pending_replies.pop_front();
                if (ok !== exp_reply.ok)
                    report($sformatf("ok %0b expected %0b", ok, exp_reply.ok));
                if (read_value !== exp_reply.read_value)
                    report($sformatf("read_value %h expected %h",
                                     read_value, exp_reply.read_value));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("lru_cache_with_ttl: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] data);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_CAPACITY)
            cur_capacity = data[CAP_BITS-1:0];
        else
            cur_ttl = data[TTL_BITS-1:0];
    endtask

    task automatic send(input request_t rq);
        reply_t rp;
        start     <= 1'b1;
        operation <= rq.op;
        key       <= rq.key;
        value     <= rq.value;
        now       <= rq.now;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rp = cache_access(rq);
        if (rq.known && rp !== rq.reply)
            report($sformatf("table row op %0d key %h disagrees with predictor",
                             rq.op, rq.key));
        pending_replies.push_back(rp);
    endtask

    task automatic send_random_run(input int count);
        request_t rq;
        int burst;
        logic [TIME_BITS-1:0] clock_now;
        clock_now = $urandom_range(0, 1000);
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst = $urandom_range(1, 20);
            end
            burst--;
            clock_now += $urandom_range(0, 12);
            rq.known = 1'b0;
            rq.reply = '0;
            rq.op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
                0:       rq.key = {$urandom, $urandom};
                1:       rq.key = '0;
                default: rq.key = key_pool[$urandom_range(0, 7)];
            endcase
            rq.value = {$urandom, $urandom};
            if ($urandom_range(0, 49) == 0)
                rq.now = {$urandom};
            else
                rq.now = clock_now;
            send(rq);
        end
        start <= 1'b0;
    endtask

    function automatic request_t row(input logic [1:0] op, input logic [KEY_BITS-1:0] k,
                                     input logic [VALUE_BITS-1:0] v,
                                     input logic [TIME_BITS-1:0] t, input logic kn,
                                     input logic o, input logic [VALUE_BITS-1:0] rv);
        request_t r;
        r.op = op;
        r.key = k;
        r.value = v;
        r.now = t;
        r.known = kn;
        r.reply.ok = o;
        r.reply.read_value = rv;
        return r;
    endfunction

    initial
    begin
        logic [KEY_BITS-1:0] ones;
        ones = '1;
        errors = 0;
        replies_seen = 0;
        idle_cycles = 0;
        live = 0;
        cur_capacity = 16;
        cur_ttl = 60;
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_rank[i] = 0;
        end
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_SET;
        key = '0;
        value = '0;
        now = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CAPACITY;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(row(OP_GET, 64'd5, 0, 0, 1, 0, 0));
        directed.push_back(row(OP_DEL, 64'd5, 0, 0, 1, 0, 0));
        directed.push_back(row(OP_SET, 64'd0, 64'd9, 0, 1, 0, 0));
        directed.push_back(row(OP_GET, 64'd0, 0, 0, 1, 0, 0));
        directed.push_back(row(OP_SET, ones, ones, 0, 1, 1, 0));
        directed.push_back(row(OP_GET, ones, 0, 10, 1, 1, ones));
        directed.push_back(row(OP_SET, 64'd7, 64'h1234, 100, 1, 1, 0));
        directed.push_back(row(OP_GET, 64'd7, 0, 159, 1, 1, 64'h1234));
        directed.push_back(row(OP_GET, 64'd7, 0, 160, 1, 0, 0));
        directed.push_back(row(OP_SET, 64'd8, 64'h55, 200, 1, 1, 0));
        directed.push_back(row(OP_SET, 64'd8, 64'h66, 260, 1, 1, 0));
        directed.push_back(row(OP_GET, 64'd8, 0, 300, 0, 0, 0));
        directed.push_back(row(OP_DEL, 64'd8, 0, 301, 1, 1, 0));
        directed.push_back(row(OP_UNUSED, 64'd8, 0, 302, 1, 0, 0));
        directed.push_back(row(OP_SET, 64'd9, ones, 32'hFFFF_FFF0, 1, 1, 0));
        directed.push_back(row(OP_GET, 64'd9, 0, 32'hFFFF_FFFE, 1, 1, ones));
        directed.push_back(row(OP_GET, 64'd9, 0, 32'hFFFF_FFFF, 1, 0, 0));
        foreach (directed[i])
            send(directed[i]);
        start <= 1'b0;

        write_reg(CFG_CAPACITY, 64'd2);
        write_reg(CFG_TTL, 64'd0);
        directed.delete();
        directed.push_back(row(OP_SET, 64'd1, 64'd11, 50, 1, 1, 0));
        directed.push_back(row(OP_SET, 64'd2, 64'd22, 50, 1, 1, 0));
        directed.push_back(row(OP_SET, 64'd2, 64'd23, 50, 1, 1, 0));
        directed.push_back(row(OP_SET, 64'd3, 64'd33, 50, 1, 1, 0));
        directed.push_back(row(OP_DEL, 64'd1, 0, 50, 1, 0, 0));
        directed.push_back(row(OP_GET, 64'd2, 0, 50, 1, 0, 0));
        foreach (directed[i])
            send(directed[i]);
        start <= 1'b0;

        for (int i = 0; i < 8; i++)
            key_pool[i] = (i == 0) ? ones : {$urandom, $urandom};
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: write_reg(CFG_CAPACITY, 64'd16);
                1: write_reg(CFG_CAPACITY, 64'd0);
                2: write_reg(CFG_CAPACITY, 64'd31);
                3: write_reg(CFG_CAPACITY, 64'd1);
                default: write_reg(CFG_CAPACITY, {$urandom, $urandom});
            endcase
            case (phase)
                0: write_reg(CFG_TTL, 64'd60);
                1: write_reg(CFG_TTL, 64'hFFFF);
                2: write_reg(CFG_TTL, 64'd0);
                default: write_reg(CFG_TTL, {$urandom, 16'd0, 16'($urandom_range(0, 80))});
            endcase
            send_random_run(100);
        end

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("covered directed edge cases and eight random phases over %0d results,",
                 replies_seen);
        $display("with capacity and lifetime swept across their extremes");
        if (errors == 0)
            $display("lru_cache_with_ttl: match");
        else
            $display("lru_cache_with_ttl: mismatch");
        $finish;
    end
endmodule
